### hw/rtl/bump_allocator_with_size_table_top_macros.svh
// assertion macros shared by the allocator checker
`ifndef BUMP_ALLOCATOR_WITH_SIZE_TABLE_TOP_MACROS_SVH
`define BUMP_ALLOCATOR_WITH_SIZE_TABLE_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define BATS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator check failed");

// next-cycle implication, disabled in reset
`define BATS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allocator check failed");

`endif

### hw/rtl/bats_pkg.sv
// types, codes and constants of the bump allocator
package bats_pkg;

   localparam int OFFSET_BITS     = 24;
   localparam int WIDE_BITS       = OFFSET_BITS + 1;
   localparam int TABLE_DEPTH_DEF = 8192;

   // command codes
   localparam logic [1:0] CMD_ALLOC   = 2'd0;
   localparam logic [1:0] CMD_QUERY   = 2'd1;
   localparam logic [1:0] CMD_RESTART = 2'd2;

   // low bits cleared when rounding a size up to a word
   localparam logic [WIDE_BITS-1:0] ALIGN_LOW = WIDE_BITS'(3);

   typedef struct packed {
      logic [1:0]             command;
      logic [OFFSET_BITS-1:0] alloc_size;
      logic [OFFSET_BITS-1:0] query_offset;
   } req_type;

   typedef struct packed {
      logic                 granted;
      logic [WIDE_BITS-1:0] block_offset;
      logic                 table_full;
      logic [WIDE_BITS-1:0] block_size;
      logic [WIDE_BITS-1:0] bytes_used;
   } rsp_type;

   // how a transaction finishes in the datapath
   typedef enum logic [2:0] {
      FIN_HOLD,
      FIN_ALLOC,
      FIN_RESTART,
      FIN_ZERO,
      FIN_LAST,
      FIN_NEXT
   } fin_type;

   // table read address source
   typedef enum logic [1:0] {
      RD_MID,
      RD_LO,
      RD_LO_NEXT
   } rd_sel_type;

   typedef struct packed {
      logic       load_req;
      logic       search_init;
      logic       step;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       take_base;
      fin_type    fin;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [1:0] command;
      logic       range_open;
      logic       lo_in_range;
      logic       match;
      logic       has_next;
   } dp_status_type;

endpackage

### hw/rtl/bats_dp.sv
// allocator datapath: pool registers, start table and search bounds
module bats_dp #(
   parameter int TABLE_DEPTH = bats_pkg::TABLE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bats_pkg::req_type                   req_item,
   input  logic                                csr_we,
   input  logic [bats_pkg::OFFSET_BITS-1:0]    csr_wdata,
   input  bats_pkg::ctrl_cmd_type              cmd,
   output bats_pkg::dp_status_type             status,
   output bats_pkg::rsp_type                   rsp_data
);
   import bats_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   logic [OFFSET_BITS-1:0] pool_ff;
   logic [WIDE_BITS-1:0]   used_ff;
   logic [CW-1:0]          count_ff;
   logic [CW-1:0]          lo_ff;
   logic [CW-1:0]          hi_ff;
   req_type                req_ff;
   logic [WIDE_BITS-1:0]   rdata_ff;
   logic [WIDE_BITS-1:0]   base_ff;
   rsp_type                rsp_ff;
   rsp_type                rsp_in;
   logic [WIDE_BITS-1:0]   table_mem [TABLE_DEPTH];

   logic [CW:0]            mid_sum;
   logic [CW-1:0]          mid_w;
   logic [CW:0]            lo_inc;
   logic [AW-1:0]          rd_addr;
   logic [WIDE_BITS:0]     fit_sum;
   logic                   grant;
   logic                   room;
   logic                   wr_en;
   logic [WIDE_BITS-1:0]   rounded;
   logic [WIDE_BITS-1:0]   used_adv;
   logic [WIDE_BITS-1:0]   qoff_w;
   logic                   less;

   // search midpoint and neighbor index
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_w   = mid_sum[CW:1];
   assign lo_inc  = {1'b0, lo_ff} + (CW+1)'(1);
   assign qoff_w  = {1'b0, req_ff.query_offset};
   assign less    = rdata_ff < qoff_w;

   // allocation check and advance
   assign fit_sum  = {1'b0, used_ff} + {2'b00, req_ff.alloc_size};
   assign grant    = (|pool_ff) && (fit_sum <= {2'b00, pool_ff});
   assign room     = count_ff < CW'(TABLE_DEPTH);
   assign rounded  = ({1'b0, req_ff.alloc_size} + ALIGN_LOW) & ~ALIGN_LOW;
   assign used_adv = used_ff + rounded;
   assign wr_en    = (cmd.fin == FIN_ALLOC) && grant && room;

   // status toward the controller
   assign status.command     = req_ff.command;
   assign status.range_open  = lo_ff < hi_ff;
   assign status.lo_in_range = lo_ff < count_ff;
   assign status.match       = rdata_ff == qoff_w;
   assign status.has_next    = lo_inc < {1'b0, count_ff};

   // table read address select
   always_comb begin
      case (cmd.rd_sel)
         RD_MID:     rd_addr = mid_w[AW-1:0];
         RD_LO:      rd_addr = lo_ff[AW-1:0];
         RD_LO_NEXT: rd_addr = lo_inc[AW-1:0];
         default:    rd_addr = mid_w[AW-1:0];
      endcase
   end

   // next result
   always_comb begin
      rsp_in = rsp_ff;
      case (cmd.fin)
         FIN_ALLOC: begin
            rsp_in.granted      = grant;
            rsp_in.block_offset = grant ? used_ff : '0;
            rsp_in.table_full   = grant && !room;
            rsp_in.block_size   = '0;
            rsp_in.bytes_used   = grant ? used_adv : used_ff;
         end
         FIN_RESTART: begin
            rsp_in = '0;
         end
         FIN_ZERO: begin
            rsp_in            = '0;
            rsp_in.bytes_used = used_ff;
         end
         FIN_LAST: begin
            rsp_in            = '0;
            rsp_in.block_size = used_ff - rdata_ff;
            rsp_in.bytes_used = used_ff;
         end
         FIN_NEXT: begin
            rsp_in            = '0;
            rsp_in.block_size = rdata_ff - base_ff;
            rsp_in.bytes_used = used_ff;
         end
         default: begin
            rsp_in = rsp_ff;
         end
      endcase
   end

   // pool length, used offset and entry count
   always_ff @(posedge clock) begin
      if (reset) begin
         pool_ff  <= '0;
         used_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (csr_we) begin
            pool_ff <= csr_wdata;
         end
         if (cmd.fin == FIN_ALLOC && grant) begin
            used_ff <= used_adv;
            if (room) begin
               count_ff <= count_ff + CW'(1);
            end
         end else if (cmd.fin == FIN_RESTART) begin
            used_ff  <= '0;
            count_ff <= '0;
         end
      end
   end

   // transaction payload, search bounds and result
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_item;
      end
      if (cmd.search_init) begin
         lo_ff <= '0;
         hi_ff <= count_ff;
      end else if (cmd.step) begin
         if (less) begin
            lo_ff <= mid_w + CW'(1);
         end else begin
            hi_ff <= mid_w;
         end
      end
      if (cmd.take_base) begin
         base_ff <= rdata_ff;
      end
      rsp_ff <= rsp_in;
   end

   // start table, one write and one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[count_ff[AW-1:0]] <= used_ff;
      end
      if (cmd.rd_en) begin
         rdata_ff <= table_mem[rd_addr];
      end
   end

   assign rsp_data = rsp_ff;

endmodule

### hw/rtl/bats_ctrl.sv
// allocator controller: sequences decode, binary search and result strobe
module bats_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  bats_pkg::dp_status_type  status,
   output logic                     busy,
   output logic                     rsp_strobe,
   output bats_pkg::ctrl_cmd_type   cmd
);
   import bats_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_PROBE,
      ST_CMP,
      ST_MATCH,
      ST_NEXT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      strobe_ff;
   logic      strobe_in;

   // next state and datapath commands
   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.rd_sel      = RD_MID;
      cmd.fin         = FIN_HOLD;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (status.command)
               CMD_ALLOC: begin
                  cmd.fin  = FIN_ALLOC;
                  state_in = ST_IDLE;
               end
               CMD_RESTART: begin
                  cmd.fin  = FIN_RESTART;
                  state_in = ST_IDLE;
               end
               CMD_QUERY: begin
                  cmd.search_init = 1'b1;
                  state_in        = ST_PROBE;
               end
               default: begin
                  cmd.fin  = FIN_ZERO;
                  state_in = ST_IDLE;
               end
            endcase
         end
         // read the midpoint, or the lower bound once the range is empty, if below the entry count
         ST_PROBE: begin
            if (status.range_open) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_MID;
               state_in   = ST_CMP;
            end else if (status.lo_in_range) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_LO;
               state_in   = ST_MATCH;
            end else begin
               cmd.fin  = FIN_ZERO;
               state_in = ST_IDLE;
            end
         end
         ST_CMP: begin
            cmd.step = 1'b1;
            state_in = ST_PROBE;
         end
         // first entry not below the offset: check it and fetch its neighbor if it has one
         ST_MATCH: begin
            if (!status.match) begin
               cmd.fin  = FIN_ZERO;
               state_in = ST_IDLE;
            end else if (status.has_next) begin
               cmd.rd_en     = 1'b1;
               cmd.rd_sel    = RD_LO_NEXT;
               cmd.take_base = 1'b1;
               state_in      = ST_NEXT;
            end else begin
               cmd.fin  = FIN_LAST;
               state_in = ST_IDLE;
            end
         end
         ST_NEXT: begin
            cmd.fin  = FIN_NEXT;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      strobe_in = (cmd.fin != FIN_HOLD);
   end

   // state and result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;

endmodule

### hw/rtl/bump_allocator_with_size_table_top.sv
// top level of the bump allocator with block start table
//
// One transaction at a time: start is taken while busy is low, and the result
// shows on rsp_data with rsp_strobe, which is high for exactly one cycle; the
// receiver cannot stall it, and busy is already low in that cycle. Allocate,
// restart and the unused command code finish in the decode state. A size query
// runs a lower-bound binary search over the recorded starts through the table's
// single registered read port, a probe and a compare state per halving, then a
// match state, and a next state when the matching entry has a successor. The
// user must write pool_length through csr_we/csr_wdata only while the block is
// idle; the block itself does not enforce it. Reset clears the pool length, the
// used offset and the entry count, and the table itself needs no clearing pass.
module bump_allocator_with_size_table_top #(
   parameter int TABLE_DEPTH = bats_pkg::TABLE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  bats_pkg::req_type                   req_item,
   input  logic                                csr_we,
   input  logic [bats_pkg::OFFSET_BITS-1:0]    csr_wdata,
   output logic                                rsp_strobe,
   output bats_pkg::rsp_type                   rsp_data
);
   import bats_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // sequencing
   bats_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   // pool state and start table
   bats_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule

### hw/rtl/bats_checker.sv
// port-level checks of the bump allocator, bound to its top level
`include "bump_allocator_with_size_table_top_macros.svh"

module bats_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input bats_pkg::rsp_type rsp_data
);
   import bats_pkg::*;

   logic accepted;

   assign accepted = start && !busy;

   // an accepted transaction keeps the block busy and silent next cycle
   `BATS_ASSERT_NEXT(a_accept_busy, clock, reset, accepted, busy && !rsp_strobe)
   // a result is strobed whenever the block becomes free again
   `BATS_ASSERT_SAME(a_done_strobe, clock, reset, $fell(busy) && !$past(reset), rsp_strobe)
   // a result is never shown while a transaction is still running
   `BATS_ASSERT_SAME(a_strobe_idle, clock, reset, rsp_strobe, !busy)
   // refused or non-allocate results carry no offset and no full flag
   `BATS_ASSERT_SAME(a_refused_clean, clock, reset, rsp_strobe && !rsp_data.granted,
      rsp_data.block_offset == '0 && !rsp_data.table_full)

endmodule

bind bump_allocator_with_size_table_top bats_checker u_bats_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

### dv/bump_allocator_with_size_table_checker.sv
// checker for the bump allocator: predicts each transaction and compares results
`timescale 1ns / 1ps

module bump_allocator_with_size_table_checker #(
   parameter int TABLE_DEPTH = bats_pkg::TABLE_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             busy,
   input  bats_pkg::req_type                req_item,
   input  logic                             csr_we,
   input  logic [bats_pkg::OFFSET_BITS-1:0] csr_wdata,
   input  logic                             rsp_strobe,
   input  bats_pkg::rsp_type                rsp_data,
   output int                               fail_count,
   output int                               pending_count
);
   import bats_pkg::*;

   // shadow of the pool state
   logic [OFFSET_BITS-1:0] pool_bytes;
   logic [WIDE_BITS-1:0]   used_bytes;
   int                     recorded;
   logic [WIDE_BITS-1:0]   start_offsets [TABLE_DEPTH];

   // predicted results, oldest first
   rsp_type awaited_results [$];

   // size of the block that starts at off, zero when no recorded start matches
   function automatic logic [WIDE_BITS-1:0] lookup_size(logic [OFFSET_BITS-1:0] off);
      for (int i = 0; i < recorded; i++) begin
         if (start_offsets[i] == WIDE_BITS'(off)) begin
            if (i + 1 < recorded) return start_offsets[i + 1] - start_offsets[i];
            return used_bytes - start_offsets[i];
         end
      end
      return '0;
   endfunction

   // apply one command to the shadow state and build its result
   function automatic rsp_type advance_pool(req_type r);
      rsp_type              res;
      logic [WIDE_BITS:0]   reach;
      logic [WIDE_BITS-1:0] rounded;
      res = '0;
      case (r.command)
         CMD_ALLOC: begin
            reach = {1'b0, used_bytes} + (WIDE_BITS + 1)'(r.alloc_size);
            if (pool_bytes != 0 && reach <= (WIDE_BITS + 1)'(pool_bytes)) begin
               res.granted      = 1'b1;
               res.block_offset = used_bytes;
               if (recorded < TABLE_DEPTH) begin
                  start_offsets[recorded] = used_bytes;
                  recorded++;
               end else begin
                  res.table_full = 1'b1;
               end
               rounded    = (WIDE_BITS'(r.alloc_size) + ALIGN_LOW) & ~ALIGN_LOW;
               used_bytes = used_bytes + rounded;
            end
         end
         CMD_QUERY: begin
            res.block_size = lookup_size(r.query_offset);
         end
         CMD_RESTART: begin
            used_bytes = '0;
            recorded   = 0;
         end
         default: begin
         end
      endcase
      res.bytes_used = used_bytes;
      return res;
   endfunction

   task automatic check_field(string field, logic [WIDE_BITS-1:0] want,
                              logic [WIDE_BITS-1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
         fail_count++;
      end
   endtask

   initial begin
      fail_count    = 0;
      pending_count = 0;
      pool_bytes    = '0;
      used_bytes    = '0;
      recorded      = 0;
   end

   // watch both channels at each rising edge
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         pool_bytes = '0;
         used_bytes = '0;
         recorded   = 0;
         awaited_results.delete();
      end else begin
         // result side first: a new transaction may start in the strobe cycle
         if (rsp_strobe) begin
            if (awaited_results.size() == 0) begin
               $error("result strobe with no transaction outstanding");
               fail_count++;
            end else begin
               want = awaited_results.pop_front();
               check_field("granted", WIDE_BITS'(want.granted),
                           WIDE_BITS'(rsp_data.granted));
               check_field("block_offset", want.block_offset, rsp_data.block_offset);
               check_field("table_full", WIDE_BITS'(want.table_full),
                           WIDE_BITS'(rsp_data.table_full));
               check_field("block_size", want.block_size, rsp_data.block_size);
               check_field("bytes_used", want.bytes_used, rsp_data.bytes_used);
            end
         end
         if (csr_we) pool_bytes = csr_wdata;
         if (start && !busy) awaited_results.push_back(advance_pool(req_item));
      end
      pending_count = awaited_results.size();
   end

endmodule

### dv/bump_allocator_with_size_table_top_tb.sv
// testbench top for the bump allocator: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module bump_allocator_with_size_table_top_tb;
   import bats_pkg::*;

   localparam logic [1:0] CMD_SPARE = 2'd3;
   localparam int         TBL_DEPTH = TABLE_DEPTH_DEF;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   req_type                req_item;
   logic                   csr_we;
   logic [OFFSET_BITS-1:0] csr_wdata;
   logic                   rsp_strobe;
   rsp_type                rsp_data;
   int                     fail_count;
   int                     pending_count;

   // stimulus-side view of recent grants
   logic [OFFSET_BITS-1:0] known_starts [$];
   logic [WIDE_BITS-1:0]   last_used;
   int                     n_results;
   int                     n_grants;
   int                     n_full;
   int                     n_hits;
   int                     n_sent;
   bit                     gaps_on;

   bump_allocator_with_size_table_top dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   bump_allocator_with_size_table_checker #(
      .TABLE_DEPTH (TBL_DEPTH)
   ) checker_i (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_item      (req_item),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .rsp_strobe    (rsp_strobe),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   initial begin
      #20_000_000;
      $display("FAIL bump_allocator_with_size_table_top");
      $finish;
   end

   // track grants and usage for stimulus shaping and the summary
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         n_results++;
         last_used = rsp_data.bytes_used;
         if (rsp_data.block_size != 0) n_hits++;
         if (rsp_data.granted) begin
            n_grants++;
            known_starts.push_back(rsp_data.block_offset[OFFSET_BITS-1:0]);
            if (known_starts.size() > 64) void'(known_starts.pop_front());
         end
         if (rsp_data.table_full) n_full++;
      end
   end

   function automatic req_type mk_req(logic [1:0] cmd, logic [OFFSET_BITS-1:0] size,
                                      logic [OFFSET_BITS-1:0] off);
      req_type r;
      r.command      = cmd;
      r.alloc_size   = size;
      r.query_offset = off;
      return r;
   endfunction

   // present one transaction, return at the falling edge after it is taken
   task automatic send_item(req_type r);
      if (r.command == CMD_RESTART) known_starts.delete();
      start    <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy);
      n_sent++;
      @(negedge clock);
   endtask

   task automatic idle_burst();
      start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clock);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic write_pool(logic [OFFSET_BITS-1:0] len);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= len;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // size mix: small, pool-relative, exact remaining fit, one past it, full range
   function automatic logic [OFFSET_BITS-1:0] pick_size(logic [OFFSET_BITS-1:0] pool);
      logic [WIDE_BITS-1:0] room;
      int unsigned          sel;
      room = (WIDE_BITS'(pool) > last_used) ? WIDE_BITS'(pool) - last_used : '0;
      sel  = $urandom_range(0, 99);
      if (sel < 45) return OFFSET_BITS'($urandom_range(0, 15));
      if (sel < 70) return OFFSET_BITS'($urandom_range(0, (pool >> 4) + 1));
      if (sel < 80) return room[OFFSET_BITS-1:0];
      if (sel < 88) return room[OFFSET_BITS-1:0] + 1'b1;
      return OFFSET_BITS'($urandom());
   endfunction

   function automatic logic [OFFSET_BITS-1:0] pick_offset();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (known_starts.size() != 0 && sel < 70)
         return known_starts[$urandom_range(0, known_starts.size() - 1)];
      if (known_starts.size() != 0 && sel < 80)
         return known_starts[$urandom_range(0, known_starts.size() - 1)] +
                OFFSET_BITS'($urandom_range(1, 3));
      return OFFSET_BITS'($urandom());
   endfunction

   // one random transaction: mostly well-formed commands, some pure noise
   task automatic random_item(logic [OFFSET_BITS-1:0] pool);
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 55)
         send_item(mk_req(CMD_ALLOC, pick_size(pool), OFFSET_BITS'($urandom())));
      else if (sel < 85)
         send_item(mk_req(CMD_QUERY, OFFSET_BITS'($urandom()), pick_offset()));
      else if (sel < 90)
         send_item(mk_req(CMD_RESTART, OFFSET_BITS'($urandom()),
                          OFFSET_BITS'($urandom())));
      else if (sel < 95)
         send_item(mk_req(CMD_SPARE, OFFSET_BITS'($urandom()), OFFSET_BITS'($urandom())));
      else
         send_item(mk_req(2'($urandom_range(0, 3)), OFFSET_BITS'($urandom()),
                          OFFSET_BITS'($urandom())));
      if (gaps_on && $urandom_range(0, 3) == 0) idle_burst();
      if (gaps_on && $urandom_range(0, 59) == 0) wait_drained();
   endtask

   task automatic run_phase(logic [OFFSET_BITS-1:0] pool, int count);
      write_pool(pool);
      gaps_on = $urandom_range(0, 2) != 0;
      repeat (count) random_item(pool);
   endtask

   logic [OFFSET_BITS-1:0] ones;
   logic [OFFSET_BITS-1:0] final_pool;

   initial begin
      ones       = {OFFSET_BITS{1'b1}};
      reset      = 1'b1;
      start      = 1'b0;
      req_item   = '0;
      csr_we     = 1'b0;
      csr_wdata  = '0;
      last_used  = '0;
      n_results  = 0;
      n_grants   = 0;
      n_full     = 0;
      n_hits     = 0;
      n_sent     = 0;
      gaps_on    = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // no pool after reset: refusal, empty table, spare code, restart
      send_item(mk_req(CMD_ALLOC, '0, '0));
      send_item(mk_req(CMD_QUERY, '0, '0));
      send_item(mk_req(CMD_SPARE, ones, ones));
      send_item(mk_req(CMD_RESTART, ones, ones));

      // full pool: rounding of small sizes and searches over them
      write_pool(ones);
      send_item(mk_req(CMD_ALLOC, 24'd0, ones));
      send_item(mk_req(CMD_ALLOC, 24'd1, '0));
      send_item(mk_req(CMD_ALLOC, 24'd3, '0));
      send_item(mk_req(CMD_ALLOC, 24'd4, '0));
      send_item(mk_req(CMD_ALLOC, 24'd5, '0));
      send_item(mk_req(CMD_QUERY, ones, 24'd0));
      send_item(mk_req(CMD_QUERY, '0, 24'd4));
      send_item(mk_req(CMD_QUERY, '0, 24'd12));
      send_item(mk_req(CMD_QUERY, '0, 24'd7));
      send_item(mk_req(CMD_QUERY, '0, ones));
      send_item(mk_req(CMD_ALLOC, ones, '0));

      // largest block fills the pool, used offset reaches bit 24
      send_item(mk_req(CMD_RESTART, '0, '0));
      send_item(mk_req(CMD_ALLOC, ones, ones));
      send_item(mk_req(CMD_QUERY, '0, 24'd0));
      send_item(mk_req(CMD_ALLOC, '0, '0));

      // pool shrunk below the used offset, then an exact fit
      write_pool(24'd16);
      send_item(mk_req(CMD_ALLOC, '0, '0));
      send_item(mk_req(CMD_RESTART, '0, '0));
      send_item(mk_req(CMD_ALLOC, 24'd16, '0));
      send_item(mk_req(CMD_ALLOC, 24'd0, '0));
      send_item(mk_req(CMD_ALLOC, 24'd1, '0));

      // random phases over a spread of pool lengths
      run_phase(24'd0, 30);
      run_phase(24'd1, 80);
      run_phase(24'd4, 80);
      run_phase(24'd100, 110);
      run_phase(24'd4096, 120);
      run_phase(24'h00ffff, 120);
      run_phase(24'd8, 60);
      run_phase(ones, 120);
      run_phase(OFFSET_BITS'($urandom()), 80);

      // last stretch back to back
      final_pool = OFFSET_BITS'($urandom_range(1024, 1 << 20));
      write_pool(final_pool);
      gaps_on = 1'b0;
      repeat (60) random_item(final_pool);

      start <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (60) @(posedge clock);

      $display("ran %0d transactions: %0d results, %0d grants, %0d with table full",
               n_sent, n_results, n_grants, n_full);
      $display("size queries hitting a block: %0d; pool lengths from zero to full range",
               n_hits);
      if (fail_count == 0 && pending_count == 0) begin
         $display("PASS bump_allocator_with_size_table_top");
      end else begin
         if (pending_count != 0) $error("%0d results never arrived", pending_count);
         $display("FAIL bump_allocator_with_size_table_top");
      end
      $finish;
   end

endmodule
